// ===== src/i2crts_pkg.sv =====
// Shared types, command codes and the result expansion table for the I2C sequencer.
package i2crts_pkg;

  // Request codes on the mode input.
  typedef enum logic [2:0] {
    MODE_WRITE_START = 3'd0,
    MODE_WRITE_DATA  = 3'd1,
    MODE_READ_START  = 3'd2,
    MODE_RECV_BYTE   = 3'd3,
    MODE_WRITE_BITS  = 3'd4,
    MODE_READ_BITS   = 3'd5
  } mode_t;

  // Commands on the result channel.
  typedef enum logic [3:0] {
    CMD_START   = 4'd0,
    CMD_RESTART = 4'd1,
    CMD_SEND    = 4'd2,
    CMD_RECEIVE = 4'd3,
    CMD_ACK     = 4'd4,
    CMD_NACK    = 4'd5,
    CMD_STOP    = 4'd6,
    CMD_HOST    = 4'd7,
    CMD_DONE    = 4'd8,
    CMD_ERROR   = 4'd9
  } cmd_t;

  // Kinds of result sequence that the front hands to the back.
  typedef enum logic [2:0] {
    JOB_SINGLE     = 3'd0,
    JOB_WSTART     = 3'd1,
    JOB_WDATA      = 3'd2,
    JOB_WDATA_STOP = 3'd3,
    JOB_RHEAD      = 3'd4,
    JOB_RECV_MORE  = 3'd5,
    JOB_RECV_LAST  = 3'd6,
    JOB_WBITS      = 3'd7
  } job_kind_t;

  // One queued job: its kind, the command of a single result and up to three bytes.
  typedef struct packed {
    job_kind_t   kind;
    cmd_t        cmd;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
  } job_t;

  // One result item.
  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  value;
    logic        last;
  } res_t;

  localparam int unsigned STEP_W = 3;

  // Result number step of a job.
  function automatic res_t result_at(input job_t job, input logic [STEP_W-1:0] step);
    res_t r;
    r = '{cmd: CMD_ERROR, value: 8'd0, last: 1'b1};
    unique case (job.kind)
      JOB_SINGLE: begin
        r = '{cmd: job.cmd, value: job.b0, last: 1'b1};
      end
      JOB_WSTART: begin
        unique case (step)
          3'd0:    r = '{cmd: CMD_START, value: 8'd0, last: 1'b0};
          3'd1:    r = '{cmd: CMD_SEND, value: job.b0, last: 1'b0};
          default: r = '{cmd: CMD_SEND, value: job.b1, last: 1'b1};
        endcase
      end
      JOB_WDATA: begin
        r = '{cmd: CMD_SEND, value: job.b0, last: 1'b1};
      end
      JOB_WDATA_STOP: begin
        unique case (step)
          3'd0:    r = '{cmd: CMD_SEND, value: job.b0, last: 1'b0};
          default: r = '{cmd: CMD_STOP, value: 8'd0, last: 1'b1};
        endcase
      end
      JOB_RHEAD: begin
        unique case (step)
          3'd0:    r = '{cmd: CMD_START, value: 8'd0, last: 1'b0};
          3'd1:    r = '{cmd: CMD_SEND, value: job.b0, last: 1'b0};
          3'd2:    r = '{cmd: CMD_SEND, value: job.b1, last: 1'b0};
          3'd3:    r = '{cmd: CMD_RESTART, value: 8'd0, last: 1'b0};
          3'd4:    r = '{cmd: CMD_SEND, value: job.b0 | 8'd1, last: 1'b0};
          default: r = '{cmd: CMD_RECEIVE, value: 8'd0, last: 1'b1};
        endcase
      end
      JOB_RECV_MORE: begin
        unique case (step)
          3'd0:    r = '{cmd: CMD_HOST, value: job.b0, last: 1'b0};
          3'd1:    r = '{cmd: CMD_ACK, value: 8'd0, last: 1'b0};
          default: r = '{cmd: CMD_RECEIVE, value: 8'd0, last: 1'b1};
        endcase
      end
      JOB_RECV_LAST: begin
        unique case (step)
          3'd0:    r = '{cmd: CMD_HOST, value: job.b0, last: 1'b0};
          3'd1:    r = '{cmd: CMD_NACK, value: 8'd0, last: 1'b0};
          default: r = '{cmd: CMD_STOP, value: 8'd0, last: 1'b1};
        endcase
      end
      JOB_WBITS: begin
        unique case (step)
          3'd0:    r = '{cmd: CMD_NACK, value: 8'd0, last: 1'b0};
          3'd1:    r = '{cmd: CMD_STOP, value: 8'd0, last: 1'b0};
          3'd2:    r = '{cmd: CMD_START, value: 8'd0, last: 1'b0};
          3'd3:    r = '{cmd: CMD_SEND, value: job.b0, last: 1'b0};
          3'd4:    r = '{cmd: CMD_SEND, value: job.b1, last: 1'b0};
          3'd5:    r = '{cmd: CMD_SEND, value: job.b2, last: 1'b0};
          default: r = '{cmd: CMD_STOP, value: 8'd0, last: 1'b1};
        endcase
      end
      default: begin
        r = '{cmd: CMD_ERROR, value: 8'd0, last: 1'b1};
      end
    endcase
    return r;
  endfunction

endpackage

// ===== src/i2c_register_transaction_sequencer_top.sv =====
// I2C register transaction sequencer: top level with front end, job queue and sequencer.
//
// Usage: the host and the byte-level I2C engine both write requests into the
// request queue (push/full): start, write data, received byte and bit-field
// requests. Results come out of the result queue (empty/pop): engine commands
// and host data, with last set on the final result of each request.
// A request is accepted whenever push is high and full is low, one per cycle.
// The front end classifies it in the accepting cycle and writes one job into
// a QUEUE_DEPTH entry job queue. The sequencer reads a job and emits one
// result per cycle into the output register while pop keeps it free, so a
// request yields between one and seven results. When the block is idle, an
// accepted request's job is registered in the job queue and its first
// result then in the output register before it shows on the result ports.
// Sustained request rate is one per cycle for single-result requests while
// pop keeps up; requests of more results are held by the sequencer, which
// emits one result per cycle to the output port.
// Reset empties the job queue and the output register and returns the
// transaction state to idle. When pop stays low the current result holds,
// the sequencer waits, the job queue fills and full rises.
module i2c_register_transaction_sequencer_top import i2crts_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  mode,
  input  logic [6:0]  slave_address,
  input  logic [7:0]  register_address,
  input  logic [7:0]  byte_count,
  input  logic [7:0]  data_byte,
  input  logic [2:0]  field_msb,
  input  logic [3:0]  field_length,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  command,
  output logic [7:0]  byte_value,
  output logic        last
);

  job_t  front_job;
  job_t  head_job;
  logic  q_full;
  logic  q_empty;
  logic  accept;
  logic  job_done;

  assign full   = q_full;
  assign accept = push && !q_full;

  // Front end: request checks and transaction state.
  i2crts_front u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .mode             (mode),
    .slave_address    (slave_address),
    .register_address (register_address),
    .byte_count       (byte_count),
    .data_byte        (data_byte),
    .field_msb        (field_msb),
    .field_length     (field_length),
    .job              (front_job)
  );

  // Job queue.
  i2crts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (front_job),
    .rd_en   (job_done),
    .rd_data (head_job),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Result sequencer.
  i2crts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job        (head_job),
    .job_valid  (!q_empty),
    .job_done   (job_done),
    .pop        (pop),
    .empty      (empty),
    .command    (command),
    .byte_value (byte_value),
    .last       (last)
  );

  // The job queue can never be full and empty at once.
  assert property (@(posedge clk) disable iff (rst) !(q_full && q_empty))
    else $error("job queue reports full and empty together");

  // An accepted request leaves at least one job queued on the next cycle.
  assert property (@(posedge clk) disable iff (rst) accept |=> !q_empty)
    else $error("accepted request did not reach the job queue");

  // Done and error results always close their request.
  assert property (@(posedge clk) disable iff (rst)
      (!empty && (command == CMD_DONE || command == CMD_ERROR)) |-> last)
    else $error("done or error result not marked last");

  // A receive command always ends its request's results.
  assert property (@(posedge clk) disable iff (rst)
      (!empty && command == CMD_RECEIVE) |-> last)
    else $error("receive command not marked last");

endmodule

// ===== src/i2crts_front.sv =====
// Request front end: checks each request against the transaction state and forms a job.
module i2crts_front import i2crts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [2:0]  mode,
  input  logic [6:0]  slave_address,
  input  logic [7:0]  register_address,
  input  logic [7:0]  byte_count,
  input  logic [7:0]  data_byte,
  input  logic [2:0]  field_msb,
  input  logic [3:0]  field_length,
  output job_t        job
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_WDATA = 3'b010,
    PH_RECV  = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_WBITS = 2'd1,
    KIND_RBITS = 2'd2
  } pend_t;

  phase_t      phase, phase_next;
  pend_t       pending_kind, pending_kind_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [6:0]  saved_slave, saved_slave_next;
  logic [7:0]  saved_register, saved_register_next;
  logic [2:0]  saved_field_msb, saved_field_msb_next;
  logic [3:0]  saved_length, saved_length_next;
  logic [7:0]  saved_value, saved_value_next;

  logic [7:0]  bytes_dec;
  logic [2:0]  shift;
  logic [8:0]  mask_wide;
  logic [7:0]  fmask;
  logic [7:0]  place_mask;
  logic [7:0]  merged;
  logic [7:0]  field_val;
  logic        field_bad;

  // Field arithmetic for the bit-field read-modify-write.
  assign bytes_dec  = bytes_left - 8'd1;
  assign shift      = saved_field_msb + 3'd1 - saved_length[2:0];
  assign mask_wide  = (9'd1 << saved_length) - 9'd1;
  assign fmask      = mask_wide[7:0];
  assign place_mask = fmask << shift;
  assign merged     = (data_byte & ~place_mask) | ((saved_value << shift) & place_mask);
  assign field_val  = (data_byte >> shift) & fmask;
  assign field_bad  = field_length > ({1'b0, field_msb} + 4'd1);

  // Classify the request and work out the next transaction state.
  always_comb begin
    phase_next           = phase;
    pending_kind_next    = pending_kind;
    bytes_left_next      = bytes_left;
    saved_slave_next     = saved_slave;
    saved_register_next  = saved_register;
    saved_field_msb_next = saved_field_msb;
    saved_length_next    = saved_length;
    saved_value_next     = saved_value;
    job = '{kind: JOB_SINGLE, cmd: CMD_ERROR, b0: 8'd0, b1: 8'd0, b2: 8'd0};

    unique case (mode_t'(mode))
      MODE_WRITE_START, MODE_READ_START: begin
        if (phase != PH_IDLE) begin
          job.cmd = CMD_ERROR;
        end else if (byte_count == 8'd0) begin
          job.cmd = CMD_DONE;
        end else begin
          saved_slave_next    = slave_address;
          saved_register_next = register_address;
          bytes_left_next     = byte_count;
          pending_kind_next   = KIND_PLAIN;
          job.b0 = {slave_address, 1'b0};
          job.b1 = register_address;
          if (mode_t'(mode) == MODE_WRITE_START) begin
            phase_next = PH_WDATA;
            job.kind   = JOB_WSTART;
          end else begin
            phase_next = PH_RECV;
            job.kind   = JOB_RHEAD;
          end
        end
      end
      MODE_WRITE_DATA: begin
        if (phase == PH_WDATA) begin
          bytes_left_next = bytes_dec;
          job.b0          = data_byte;
          if (bytes_dec == 8'd0) begin
            phase_next = PH_IDLE;
            job.kind   = JOB_WDATA_STOP;
          end else begin
            job.kind = JOB_WDATA;
          end
        end
      end
      MODE_RECV_BYTE: begin
        if (phase == PH_RECV) begin
          bytes_left_next = bytes_dec;
          if (pending_kind == KIND_PLAIN) begin
            job.b0 = data_byte;
            if (bytes_dec != 8'd0) begin
              job.kind = JOB_RECV_MORE;
            end else begin
              phase_next = PH_IDLE;
              job.kind   = JOB_RECV_LAST;
            end
          end else begin
            phase_next        = PH_IDLE;
            bytes_left_next   = 8'd0;
            pending_kind_next = KIND_PLAIN;
            if (pending_kind == KIND_RBITS) begin
              job.kind = JOB_RECV_LAST;
              job.b0   = field_val;
            end else begin
              job.kind = JOB_WBITS;
              job.b0   = {saved_slave, 1'b0};
              job.b1   = saved_register;
              job.b2   = merged;
            end
          end
        end
      end
      MODE_WRITE_BITS, MODE_READ_BITS: begin
        if (phase != PH_IDLE || field_bad) begin
          job.cmd = CMD_ERROR;
        end else if (mode_t'(mode) == MODE_READ_BITS && field_length == 4'd0) begin
          job.cmd = CMD_HOST;
        end else begin
          saved_slave_next     = slave_address;
          saved_register_next  = register_address;
          saved_field_msb_next = field_msb;
          saved_length_next    = field_length;
          bytes_left_next      = 8'd1;
          phase_next           = PH_RECV;
          if (mode_t'(mode) == MODE_WRITE_BITS) begin
            saved_value_next  = data_byte;
            pending_kind_next = KIND_WBITS;
          end else begin
            saved_value_next  = 8'd0;
            pending_kind_next = KIND_RBITS;
          end
          job.kind = JOB_RHEAD;
          job.b0   = {slave_address, 1'b0};
          job.b1   = register_address;
        end
      end
      default: begin
        job.cmd = CMD_ERROR;
      end
    endcase
  end

  // Transaction state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      pending_kind <= KIND_PLAIN;
      bytes_left   <= 8'd0;
    end else if (accept) begin
      phase        <= phase_next;
      pending_kind <= pending_kind_next;
      bytes_left   <= bytes_left_next;
    end
  end

  // Saved request fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      saved_slave     <= 7'd0;
      saved_register  <= 8'd0;
      saved_field_msb <= 3'd0;
      saved_length    <= 4'd0;
      saved_value     <= 8'd0;
    end else if (accept) begin
      saved_slave     <= saved_slave_next;
      saved_register  <= saved_register_next;
      saved_field_msb <= saved_field_msb_next;
      saved_length    <= saved_length_next;
      saved_value     <= saved_value_next;
    end
  end

endmodule

// ===== src/i2crts_queue.sv =====
// Small job queue between the front end and the result sequencer.
module i2crts_queue import i2crts_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  job_t  wr_data,
  input  logic  rd_en,
  output job_t  rd_data,
  output logic  full,
  output logic  empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  job_t              slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  // Slot storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/i2crts_back.sv =====
// Result sequencer: expands each queued job into its results, one per cycle unless pop stalls it.
module i2crts_back import i2crts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  job_t        job,
  input  logic        job_valid,
  output logic        job_done,
  input  logic        pop,
  output logic        empty,
  output logic [3:0]  command,
  output logic [7:0]  byte_value,
  output logic        last
);

  logic [STEP_W-1:0]  step;
  logic               out_valid;
  logic               advance;
  logic               load;
  res_t               res;
  res_t               out_res;

  assign res      = result_at(job, step);
  assign advance  = !out_valid || pop;
  assign load     = advance && job_valid;
  assign job_done = load && res.last;

  assign empty      = !out_valid;
  assign command    = out_res.cmd;
  assign byte_value = out_res.value;
  assign last       = out_res.last;

  // Step counter within the current job.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (load) begin
      step <= res.last ? '0 : step + STEP_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule
